// ===== hdl/gsp_pkg.sv =====
// ----------------------------------------------------------------------------
// Gain-scheduled PID package
// Widths, register indexes and payload types shared by the PID step core and
// its channel interfaces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gsp_pkg;

  localparam int GAIN_FRAC_BITS = 8;
  localparam int SAMPLE_W       = 16;

  localparam int GAIN_W  = 20;
  localparam int GAINS_W = 3 * GAIN_W;
  localparam int ILIM_W  = 16;
  localparam int ILIMS_W = 3 * ILIM_W;
  localparam int EDGE_W  = 16;
  localparam int EDGES_W = 2 * EDGE_W;
  localparam int OLIM_W  = SAMPLE_W - 1;

  localparam int ERR_W  = SAMPLE_W + 1;
  localparam int DIFF_W = ERR_W + 1;
  localparam int SUM_W  = 32;
  localparam int P_W    = GAIN_W + ERR_W;
  localparam int I_W    = GAIN_W + SUM_W;
  localparam int D_W    = GAIN_W + DIFF_W;
  localparam int TOT_W  = I_W + 2;

  localparam int DATA_W = 64;
  localparam int ADDR_W = 6;
  localparam int IDX_W  = 3;

  localparam logic [OLIM_W-1:0] OLIM_RESET = {OLIM_W{1'b1}};

  localparam logic [IDX_W-1:0] REG_GAINS_LOW       = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAINS_MID       = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAINS_HIGH      = 3'd2;
  localparam logic [IDX_W-1:0] REG_INTEGRAL_LIMITS = 3'd3;
  localparam logic [IDX_W-1:0] REG_BAND_EDGES      = 3'd4;
  localparam logic [IDX_W-1:0] REG_OUTPUT_LIMIT    = 3'd5;
  localparam logic [IDX_W-1:0] REG_TARGET          = 3'd6;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [GAIN_W-1:0]   gain_t;

endpackage

// ===== hdl/gsp_sample_if.sv =====
// ----------------------------------------------------------------------------
// Feedback sample channel
// Valid/ready channel carrying one signed feedback sample per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gsp_sample_if;
  import gsp_pkg::*;

  logic    valid;
  logic    ready;
  sample_t feedback;

  modport source (output valid, output feedback, input ready);
  modport sink   (input valid, input feedback, output ready);
endinterface

// ===== hdl/gsp_result_if.sv =====
// ----------------------------------------------------------------------------
// Drive result channel
// Valid/ready channel carrying one clamped drive value and its clamp flag per
// beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gsp_result_if;
  import gsp_pkg::*;

  logic    valid;
  logic    ready;
  sample_t drive;
  logic    output_clamped;

  modport source (output valid, output drive, output output_clamped, input ready);
  modport sink   (input valid, input drive, input output_clamped, output ready);
endinterface

// ===== hdl/gain_scheduled_pid_step_core.sv =====
// ----------------------------------------------------------------------------
// Gain-scheduled PID step core
// Each sample beat moves through the operand, product and output registers.
// Throughput: one sample beat per cycle unless the result channel stalls,
// set by the three-stage pipeline of operand, product and output registers,
// each with its own valid bit.
// Reset: synchronous; pipeline empty, error state zero, gains and limits zero,
// output limit at full scale and target zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gain_scheduled_pid_step_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gsp_pkg::ADDR_W-1:0]   paddr,
  input  logic [gsp_pkg::DATA_W-1:0]   pwdata,
  output logic [gsp_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  gsp_sample_if.sink                   sample,
  gsp_result_if.source                 result
);
  import gsp_pkg::*;

  logic [GAINS_W-1:0] gains_low;
  logic [GAINS_W-1:0] gains_mid;
  logic [GAINS_W-1:0] gains_high;
  logic [ILIMS_W-1:0] integral_limits;
  logic [EDGES_W-1:0] band_edges;
  logic [OLIM_W-1:0]  output_limit;
  sample_t            target;

  logic [IDX_W-1:0] reg_idx;
  logic             cfg_write;

  logic signed [ERR_W-1:0] previous_error;
  logic signed [SUM_W-1:0] error_sum;

  logic v1, v2, ov;
  logic o_free, s2_free, s1_free;
  logic load_s1, load_s2, load_o;

  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W-1:0]   tgt_ext;
  logic [ERR_W-1:0]          mag;
  logic signed [SUM_W:0]     sum_wide;
  logic signed [SUM_W-1:0]   error_sum_next;
  logic signed [DIFF_W-1:0]  diff;
  logic [GAINS_W-1:0]        gains_sel;
  logic [ILIM_W-1:0]         ilim_sel;

  logic signed [ERR_W-1:0]  s1_err;
  logic signed [SUM_W-1:0]  s1_sum;
  logic signed [DIFF_W-1:0] s1_diff;
  gain_t                    s1_kp, s1_ki, s1_kd;
  logic [ILIM_W-1:0]        s1_ilim;

  logic signed [P_W-1:0] s2_p;
  logic signed [I_W-1:0] s2_i;
  logic signed [D_W-1:0] s2_d;
  logic [ILIM_W-1:0]     s2_ilim;

  logic signed [I_W-1:0]   ilim_s;
  logic signed [I_W-1:0]   i_clamped;
  logic signed [TOT_W-1:0] total;
  logic signed [TOT_W-1:0] floored;
  logic signed [TOT_W-1:0] lim_s;
  sample_t                 drive_next;
  logic                    clamped_next;

  sample_t drive_q;
  logic    clamped_q;

  // Configuration port.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[ADDR_W-1:ADDR_W-IDX_W];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains_low       <= '0;
      gains_mid       <= '0;
      gains_high      <= '0;
      integral_limits <= '0;
      band_edges      <= '0;
      output_limit    <= OLIM_RESET;
      target          <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_GAINS_LOW:       gains_low       <= pwdata[GAINS_W-1:0];
        REG_GAINS_MID:       gains_mid       <= pwdata[GAINS_W-1:0];
        REG_GAINS_HIGH:      gains_high      <= pwdata[GAINS_W-1:0];
        REG_INTEGRAL_LIMITS: integral_limits <= pwdata[ILIMS_W-1:0];
        REG_BAND_EDGES:      band_edges      <= pwdata[EDGES_W-1:0];
        REG_OUTPUT_LIMIT:    output_limit    <= pwdata[OLIM_W-1:0];
        REG_TARGET:          target          <= pwdata[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GAINS_LOW:       prdata = DATA_W'(gains_low);
      REG_GAINS_MID:       prdata = DATA_W'(gains_mid);
      REG_GAINS_HIGH:      prdata = DATA_W'(gains_high);
      REG_INTEGRAL_LIMITS: prdata = DATA_W'(integral_limits);
      REG_BAND_EDGES:      prdata = DATA_W'(band_edges);
      REG_OUTPUT_LIMIT:    prdata = DATA_W'(output_limit);
      REG_TARGET:          prdata = DATA_W'($unsigned(target));
      default:             prdata = '0;
    endcase
  end

  // Pipeline flow control.
  assign o_free  = !ov || result.ready;
  assign s2_free = !v2 || o_free;
  assign s1_free = !v1 || s2_free;
  assign load_o  = v2 && o_free;
  assign load_s2 = v1 && s2_free;
  assign sample.ready = s1_free;
  assign load_s1 = sample.valid && s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      ov <= 1'b0;
    end else begin
      v1 <= load_s1 || (v1 && !s2_free);
      v2 <= load_s2 || (v2 && !o_free);
      ov <= load_o || (ov && !result.ready);
    end
  end

  // Error, saturating sum, difference and band choice.
  always_comb begin
    tgt_ext  = ERR_W'(target);
    err      = tgt_ext - ERR_W'(sample.feedback);
    mag      = tgt_ext[ERR_W-1] ? $unsigned(-tgt_ext) : $unsigned(tgt_ext);
    sum_wide = (SUM_W + 1)'(error_sum) + (SUM_W + 1)'(err);
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      error_sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                       : {1'b0, {(SUM_W - 1){1'b1}}};
    end else begin
      error_sum_next = sum_wide[SUM_W-1:0];
    end
    diff = DIFF_W'(err) - DIFF_W'(previous_error);
    if (mag <= ERR_W'(band_edges[EDGE_W-1:0])) begin
      gains_sel = gains_low;
      ilim_sel  = integral_limits[ILIM_W-1:0];
    end else if (mag <= ERR_W'(band_edges[2*EDGE_W-1:EDGE_W])) begin
      gains_sel = gains_mid;
      ilim_sel  = integral_limits[2*ILIM_W-1:ILIM_W];
    end else begin
      gains_sel = gains_high;
      ilim_sel  = integral_limits[3*ILIM_W-1:2*ILIM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      error_sum      <= '0;
    end else if (load_s1) begin
      previous_error <= err;
      error_sum      <= error_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_s1) begin
      s1_err  <= err;
      s1_sum  <= error_sum_next;
      s1_diff <= diff;
      s1_kp   <= gains_sel[GAIN_W-1:0];
      s1_ki   <= gains_sel[2*GAIN_W-1:GAIN_W];
      s1_kd   <= gains_sel[3*GAIN_W-1:2*GAIN_W];
      s1_ilim <= ilim_sel;
    end
  end

  // Products.
  always_ff @(posedge clk) begin
    if (load_s2) begin
      s2_p    <= P_W'(s1_kp) * P_W'(s1_err);
      s2_i    <= I_W'(s1_ki) * I_W'(s1_sum);
      s2_d    <= D_W'(s1_kd) * D_W'(s1_diff);
      s2_ilim <= s1_ilim;
    end
  end

  // Integral clamp, sum, floor and output clamp.
  always_comb begin
    ilim_s = $signed(I_W'(s2_ilim) << GAIN_FRAC_BITS);
    if (s2_i > ilim_s) begin
      i_clamped = ilim_s;
    end else if (s2_i < -ilim_s) begin
      i_clamped = -ilim_s;
    end else begin
      i_clamped = s2_i;
    end
    total   = TOT_W'(s2_p) + TOT_W'(i_clamped) + TOT_W'(s2_d);
    floored = total >>> GAIN_FRAC_BITS;
    lim_s   = $signed(TOT_W'(output_limit));
    if (floored > lim_s) begin
      drive_next   = SAMPLE_W'(lim_s);
      clamped_next = 1'b1;
    end else if (floored < -lim_s) begin
      drive_next   = SAMPLE_W'(-lim_s);
      clamped_next = 1'b1;
    end else begin
      drive_next   = SAMPLE_W'(floored);
      clamped_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_o) begin
      drive_q   <= drive_next;
      clamped_q <= clamped_next;
    end
  end

  assign result.valid          = ov;
  assign result.drive          = drive_q;
  assign result.output_clamped = clamped_q;

endmodule

// ===== dv/gsp_drive_checker.sv =====
// ----------------------------------------------------------------------------
// Gain-scheduled PID drive checker
// Follows register writes on the configuration port, works out the drive beat
// that each accepted feedback beat should produce, and compares every accepted
// drive beat field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gsp_drive_checker
  import gsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              fb_valid,
  input  logic              fb_ready,
  input  sample_t           fb_value,
  input  logic              drv_valid,
  input  logic              drv_ready,
  input  sample_t           drv_value,
  input  logic              drv_clamped,
  output int                mismatches,
  output int                outstanding
);

  localparam longint ACC_MAX    = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint ACC_MIN    = -(longint'(1) <<< (SUM_W - 1));
  localparam int     REPORT_CAP = 100;

  typedef struct packed {
    sample_t drive;
    logic    clamped;
  } drive_beat_t;

  logic [GAINS_W-1:0]      gains_lo;
  logic [GAINS_W-1:0]      gains_md;
  logic [GAINS_W-1:0]      gains_hi;
  logic [ILIMS_W-1:0]      int_limits;
  logic [EDGES_W-1:0]      band_tops;
  logic [OLIM_W-1:0]       out_limit;
  sample_t                 setpoint;
  logic signed [ERR_W-1:0] last_error;
  logic signed [SUM_W-1:0] err_accum;
  drive_beat_t             pending_drives[$];
  drive_beat_t             oldest;
  int                      fault_tally = 0;

  assign mismatches = fault_tally;

  function automatic drive_beat_t pid_step(input sample_t fb);
    drive_beat_t        beat;
    logic [GAINS_W-1:0] band_gains;
    logic [ILIM_W-1:0]  band_cap;
    gain_t              kp;
    gain_t              ki;
    gain_t              kd;
    longint             err;
    longint             mag;
    longint             acc;
    longint             p_term;
    longint             i_term;
    longint             d_term;
    longint             i_bound;
    longint             total;
    longint             lim;
    err = longint'(setpoint) - longint'(fb);
    mag = (setpoint < 0) ? -longint'(setpoint) : longint'(setpoint);
    if (mag <= longint'(band_tops[EDGE_W-1:0])) begin
      band_gains = gains_lo;
      band_cap   = int_limits[ILIM_W-1:0];
    end else if (mag <= longint'(band_tops[EDGES_W-1:EDGE_W])) begin
      band_gains = gains_md;
      band_cap   = int_limits[2*ILIM_W-1:ILIM_W];
    end else begin
      band_gains = gains_hi;
      band_cap   = int_limits[ILIMS_W-1:2*ILIM_W];
    end
    kp = band_gains[GAIN_W-1:0];
    ki = band_gains[2*GAIN_W-1:GAIN_W];
    kd = band_gains[GAINS_W-1:2*GAIN_W];

    acc = longint'(err_accum) + err;
    if (acc > ACC_MAX) acc = ACC_MAX;
    else if (acc < ACC_MIN) acc = ACC_MIN;
    err_accum = acc[SUM_W-1:0];

    p_term = longint'(kp) * err;
    i_term = longint'(ki) * acc;
    d_term = longint'(kd) * (err - longint'(last_error));
    last_error = err[ERR_W-1:0];

    i_bound = longint'(band_cap) <<< GAIN_FRAC_BITS;
    if (i_term > i_bound) i_term = i_bound;
    else if (i_term < -i_bound) i_term = -i_bound;

    // An arithmetic shift of the exact sum rounds towards minus infinity.
    total = (p_term + i_term + d_term) >>> GAIN_FRAC_BITS;
    lim   = longint'(out_limit);
    beat.clamped = 1'b1;
    if (total > lim) total = lim;
    else if (total < -lim) total = -lim;
    else beat.clamped = 1'b0;
    beat.drive = total[SAMPLE_W-1:0];
    return beat;
  endfunction

  task automatic flag(input string field, input longint want, input longint got);
    if (fault_tally < REPORT_CAP)
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
    fault_tally++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      gains_lo   = '0;
      gains_md   = '0;
      gains_hi   = '0;
      int_limits = '0;
      band_tops  = '0;
      out_limit  = OLIM_RESET;
      setpoint   = '0;
      last_error = '0;
      err_accum  = '0;
      pending_drives.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1 -: IDX_W])
          REG_GAINS_LOW:       gains_lo   = pwdata[GAINS_W-1:0];
          REG_GAINS_MID:       gains_md   = pwdata[GAINS_W-1:0];
          REG_GAINS_HIGH:      gains_hi   = pwdata[GAINS_W-1:0];
          REG_INTEGRAL_LIMITS: int_limits = pwdata[ILIMS_W-1:0];
          REG_BAND_EDGES:      band_tops  = pwdata[EDGES_W-1:0];
          REG_OUTPUT_LIMIT:    out_limit  = pwdata[OLIM_W-1:0];
          REG_TARGET:          setpoint   = pwdata[SAMPLE_W-1:0];
          default: ;
        endcase
      end
      if (drv_valid && drv_ready) begin
        if (pending_drives.size() == 0) begin
          if (fault_tally < REPORT_CAP)
            $error("drive beat %0d arrived with no prediction outstanding", drv_value);
          fault_tally++;
        end else begin
          oldest = pending_drives.pop_front();
          if (drv_value !== oldest.drive)
            flag("drive", longint'(oldest.drive), longint'(drv_value));
          if (drv_clamped !== oldest.clamped)
            flag("output_clamped", longint'(oldest.clamped), longint'(drv_clamped));
        end
      end
      if (fb_valid && fb_ready)
        pending_drives.push_back(pid_step(fb_value));
    end
    outstanding <= pending_drives.size();
  end

endmodule

// ===== dv/tb_gain_scheduled_pid_step_core.sv =====
// ----------------------------------------------------------------------------
// Gain-scheduled PID step core testbench
// Drives feedback beats and register writes into the core with random gaps on
// both channels: a directed pass over band choice, field extremes and zero
// limits, then random gains, limits, edges and targets, and finally a pure
// integral run that swings the error sum one way and back again. The drive
// checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gain_scheduled_pid_step_core;
  import gsp_pkg::*;

  localparam int IDLE_LIMIT  = 1000;
  localparam int TAIL_CYCLES = 8;
  localparam int TRIM_ITEMS  = 30;
  localparam int TRIM_ROUNDS = 28;
  localparam int SOAK_ITEMS  = 25;

  localparam logic [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
  localparam logic [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W-1){1'b0}}};

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                mismatches;
  int                outstanding;
  bit                no_idle;
  sample_t           cur_target;
  logic [EDGE_W-1:0] low_edge;
  logic [EDGE_W-1:0] mid_edge;

  gsp_sample_if sample_ch ();
  gsp_result_if result_ch ();

  gain_scheduled_pid_step_core uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sample  (sample_ch),
    .result  (result_ch)
  );

  gsp_drive_checker drive_check (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fb_valid    (sample_ch.valid),
    .fb_ready    (sample_ch.ready),
    .fb_value    (sample_ch.feedback),
    .drv_valid   (result_ch.valid),
    .drv_ready   (result_ch.ready),
    .drv_value   (result_ch.drive),
    .drv_clamped (result_ch.output_clamped),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, {(ADDR_W-IDX_W){1'b0}}};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_target(input sample_t t);
    write_reg(REG_TARGET, {{(DATA_W-SAMPLE_W){1'b0}}, t});
    cur_target = t;
  endtask

  task automatic set_edges(input logic [EDGE_W-1:0] low_top, input logic [EDGE_W-1:0] mid_top);
    write_reg(REG_BAND_EDGES, DATA_W'({mid_top, low_top}));
    low_edge = low_top;
    mid_edge = mid_top;
  endtask

  task automatic send_feedback(input sample_t fb);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid    <= 1'b1;
    sample_ch.feedback <= fb;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  task automatic settle();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    logic [GAIN_W-1:0] g;
    case ($urandom_range(0, 7))
      0:       g = GAIN_MAX;
      1:       g = GAIN_MIN;
      2:       g = '0;
      3:       g = GAIN_W'($urandom());
      4:       g = GAIN_W'(int'($urandom_range(0, 4095)) - 2048);
      default: g = GAIN_W'(int'($urandom_range(0, 511)) - 256);
    endcase
    return g;
  endfunction

  function automatic logic [ILIM_W-1:0] pick_limit();
    logic [ILIM_W-1:0] l;
    case ($urandom_range(0, 5))
      0:       l = '0;
      1:       l = '1;
      2, 3:    l = ILIM_W'($urandom_range(0, 300));
      default: l = ILIM_W'($urandom());
    endcase
    return l;
  endfunction

  function automatic sample_t clip_sample(input int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return sample_t'(v);
  endfunction

  function automatic sample_t pick_target();
    int v;
    case ($urandom_range(0, 7))
      0:       v = -32768;
      1:       v = 32767;
      2:       v = 0;
      3, 4:    v = int'(low_edge) + int'($urandom_range(0, 2)) - 1;
      5:       v = int'(mid_edge) + int'($urandom_range(0, 2)) - 1;
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return clip_sample(v);
  endfunction

  function automatic sample_t pick_feedback();
    int v;
    case ($urandom_range(0, 9))
      0:       v = -32768;
      1:       v = 32767;
      2, 3:    v = int'(cur_target) + int'($urandom_range(0, 64)) - 32;
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    return clip_sample(v);
  endfunction

  task automatic shuffle_config();
    logic [ILIM_W-1:0] a;
    logic [ILIM_W-1:0] b;
    logic [ILIM_W-1:0] t;
    write_reg(REG_GAINS_LOW, DATA_W'({pick_gain(), pick_gain(), pick_gain()}));
    write_reg(REG_GAINS_MID, DATA_W'({pick_gain(), pick_gain(), pick_gain()}));
    write_reg(REG_GAINS_HIGH, DATA_W'({pick_gain(), pick_gain(), pick_gain()}));
    write_reg(REG_INTEGRAL_LIMITS, DATA_W'({pick_limit(), pick_limit(), pick_limit()}));
    a = pick_limit();
    b = pick_limit();
    // Edges are mostly in order; the rest are left crossed.
    if (a > b && $urandom_range(0, 4) != 0) begin
      t = a;
      a = b;
      b = t;
    end
    set_edges(a, b);
    a = pick_limit();
    write_reg(REG_OUTPUT_LIMIT, DATA_W'(a[OLIM_W-1:0]));
  endtask

  initial begin : sink_side
    int stall;
    result_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) || psel)
        quiet = 0;
      else
        quiet++;
    end
    $display("gain_scheduled_pid_step_core verification failed");
    $finish;
  end

  initial begin : stimulus
    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    sample_ch.valid    <= 1'b0;
    sample_ch.feedback <= '0;
    no_idle            = 1'b0;
    cur_target         = '0;
    low_edge           = '0;
    mid_edge           = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // With every gain at zero the drive stays at zero.
    send_feedback(sample_t'(-32768));
    send_feedback(sample_t'(32767));
    settle();

    write_reg(REG_GAINS_LOW, DATA_W'({20'hFFF00, 20'd2, 20'd384}));
    write_reg(REG_GAINS_MID, DATA_W'({GAIN_MAX, GAIN_MIN, GAIN_MAX}));
    write_reg(REG_GAINS_HIGH, DATA_W'({GAIN_MIN, GAIN_MAX, GAIN_MIN}));
    write_reg(REG_INTEGRAL_LIMITS, DATA_W'({16'd100, 16'd0, 16'hFFFF}));
    set_edges(16'd1000, 16'd2000);
    write_reg(REG_OUTPUT_LIMIT, DATA_W'(OLIM_RESET));
    set_target(sample_t'(1000));
    send_feedback(sample_t'(0));
    send_feedback(sample_t'(1));
    send_feedback(sample_t'(-1));
    send_feedback(sample_t'(32767));
    send_feedback(sample_t'(-32768));
    settle();
    set_target(sample_t'(-1001));
    send_feedback(sample_t'(0));
    send_feedback(sample_t'(-32768));
    settle();
    set_target(sample_t'(2000));
    send_feedback(sample_t'(5));
    settle();
    set_target(sample_t'(2001));
    send_feedback(sample_t'(0));
    send_feedback(sample_t'(32767));
    settle();
    set_target(sample_t'(-32768));
    send_feedback(sample_t'(32767));
    settle();

    // Crossed edges: the low band reaches past the mid band top.
    set_edges(16'd3000, 16'd500);
    set_target(sample_t'(2000));
    send_feedback(sample_t'(-2000));
    settle();
    set_target(sample_t'(3001));
    send_feedback(sample_t'(0));
    settle();

    write_reg(REG_OUTPUT_LIMIT, DATA_W'(0));
    send_feedback(sample_t'(32767));
    send_feedback(sample_t'(-32768));
    settle();
    write_reg(REG_OUTPUT_LIMIT, DATA_W'(1));
    set_edges(16'hFFFF, 16'hFFFF);
    set_target(sample_t'(32767));
    send_feedback(sample_t'(-32768));
    send_feedback(sample_t'(32767));
    settle();

    for (int round = 0; round < TRIM_ROUNDS; round++) begin
      if (round % 4 == 0)
        shuffle_config();
      no_idle = ($urandom_range(0, 3) == 0);
      set_target(pick_target());
      repeat (TRIM_ITEMS) begin
        send_feedback(pick_feedback());
        if ($urandom_range(0, 99) == 0)
          settle();
      end
      settle();
    end

    // Swing the error sum hard one way and back; the pure integral drive
    // shows whether it follows the running sum exactly.
    no_idle = 1'b1;
    write_reg(REG_GAINS_LOW, DATA_W'({20'd0, 20'd1, 20'd0}));
    write_reg(REG_GAINS_MID, DATA_W'({20'd0, 20'd1, 20'd0}));
    write_reg(REG_GAINS_HIGH, DATA_W'({20'd0, 20'd1, 20'd0}));
    write_reg(REG_INTEGRAL_LIMITS, DATA_W'({3{16'hFFFF}}));
    write_reg(REG_OUTPUT_LIMIT, DATA_W'(OLIM_RESET));
    set_target(sample_t'(32767));
    repeat (SOAK_ITEMS) send_feedback(sample_t'(-32768));
    settle();
    set_target(sample_t'(-32768));
    repeat (2 * SOAK_ITEMS) send_feedback(sample_t'(32767));
    settle();
    set_target(sample_t'(32767));
    repeat (SOAK_ITEMS) send_feedback(sample_t'(-32768));
    settle();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (outstanding != 0)
      $error("%0d drive beats never arrived", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("gain_scheduled_pid_step_core verification clean");
    end else begin
      $display("gain_scheduled_pid_step_core verification failed");
    end
    $finish;
  end

endmodule
